/* sv/double_ended_queue_defines.svh */
// ----------------------------------------------------------------------------
// double_ended_queue_defines
// Assertion macros for the deque datapath.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// check a property on every rising clock edge outside reset
`define DQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising clock edge, reset included
`define DQ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/dq_pkg.sv */
// ----------------------------------------------------------------------------
// dq_pkg
// Types, codes and default sizes for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

   localparam int DQ_DEPTH      = 64;
   localparam int DQ_WORD_WIDTH = 32;

   localparam logic [1:0] ACT_PUSH_RIGHT = 2'd0;
   localparam logic [1:0] ACT_POP_LEFT   = 2'd1;
   localparam logic [1:0] ACT_POP_RIGHT  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_OUT
   } dq_state_type;

   typedef struct packed {
      logic exec;
      logic load;
   } dq_cmd_type;

   typedef struct packed {
      logic need_read;
   } dq_sts_type;

endpackage

/* sv/dq_ctrl.sv */
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: accept a request beat, wait for the end-word reload when a pop
// needs one, present the response beat.
// ----------------------------------------------------------------------------
module dq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  dq_pkg::dq_sts_type sts,
   output dq_pkg::dq_cmd_type cmd
);
   import dq_pkg::*;

   dq_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.exec = 1'b1;
               state_in = sts.need_read ? ST_READ : ST_OUT;
            end
         end
         ST_READ: begin
            cmd.load = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* sv/dq_datapath.sv */
// ----------------------------------------------------------------------------
// dq_datapath
// Ring store, head and fill registers, cached end words and result registers.
// ----------------------------------------------------------------------------
`include "double_ended_queue_defines.svh"

module dq_datapath #(
   parameter int DEPTH      = dq_pkg::DQ_DEPTH,
   parameter int WORD_WIDTH = dq_pkg::DQ_WORD_WIDTH,
   parameter int AW         = $clog2(DEPTH),
   parameter int CW         = $clog2(DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dq_pkg::dq_cmd_type    cmd,
   output dq_pkg::dq_sts_type    sts,
   input  logic [1:0]            req_action,
   input  logic [WORD_WIDTH-1:0] req_item,
   output logic [WORD_WIDTH-1:0] rsp_popped,
   output logic                  rsp_pop_valid,
   output logic                  rsp_error,
   output logic [WORD_WIDTH-1:0] rsp_left_word,
   output logic [WORD_WIDTH-1:0] rsp_right_word,
   output logic                  rsp_empty_res,
   output logic [CW-1:0]         rsp_count
);
   import dq_pkg::*;

   localparam logic [AW:0]   DEPTH_V = (AW + 1)'(DEPTH);
   localparam logic [CW-1:0] FULL_V  = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_V   = CW'(1);
   localparam logic [CW-1:0] TWO_V   = CW'(2);

   function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
      logic [AW:0] r;
      r = (s >= DEPTH_V) ? (s - DEPTH_V) : s;
      return r[AW-1:0];
   endfunction

   logic [WORD_WIDTH-1:0] mem [DEPTH];

   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         fill_ff, fill_in;
   logic [WORD_WIDTH-1:0] left_ff, left_in;
   logic [WORD_WIDTH-1:0] right_ff, right_in;
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic [WORD_WIDTH-1:0] popped_ff, popped_in;
   logic                  pop_valid_ff, pop_valid_in;
   logic                  error_ff, error_in;
   logic                  load_left_ff, load_left_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [AW-1:0]         rd_addr;
   logic                  is_empty;
   logic                  is_full;
   logic                  has_two;

   assign is_empty = (fill_ff == '0);
   assign is_full  = (fill_ff >= FULL_V);
   assign has_two  = (fill_ff >= TWO_V);

   assign sts.need_read = has_two &&
                          ((req_action == ACT_POP_LEFT) || (req_action == ACT_POP_RIGHT));

   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      popped_in    = popped_ff;
      pop_valid_in = pop_valid_ff;
      error_in     = error_ff;
      load_left_in = load_left_ff;
      wr_en        = 1'b0;
      wr_addr      = wrap({1'b0, head_ff} + (AW + 1)'(fill_ff));
      rd_addr      = wrap({1'b0, head_ff} + (AW + 1)'(1));
      if (cmd.exec) begin
         popped_in    = '0;
         pop_valid_in = 1'b0;
         error_in     = 1'b0;
         case (req_action)
            ACT_PUSH_RIGHT: begin
               if (is_full) begin
                  error_in = 1'b1;
               end else begin
                  wr_en    = 1'b1;
                  fill_in  = fill_ff + ONE_V;
                  right_in = req_item;
                  if (is_empty) begin
                     left_in = req_item;
                  end
               end
            end
            ACT_POP_LEFT: begin
               if (is_empty) begin
                  error_in = 1'b1;
               end else begin
                  popped_in    = left_ff;
                  pop_valid_in = 1'b1;
                  head_in      = wrap({1'b0, head_ff} + (AW + 1)'(1));
                  fill_in      = fill_ff - ONE_V;
                  load_left_in = 1'b1;
               end
            end
            ACT_POP_RIGHT: begin
               if (is_empty) begin
                  error_in = 1'b1;
               end else begin
                  popped_in    = right_ff;
                  pop_valid_in = 1'b1;
                  fill_in      = fill_ff - ONE_V;
                  load_left_in = 1'b0;
                  rd_addr      = wrap({1'b0, head_ff} + (AW + 1)'(fill_ff - TWO_V));
               end
            end
            default: begin
               error_in = 1'b1;
            end
         endcase
      end
      if (cmd.load) begin
         if (load_left_ff) begin
            left_in = rd_data_ff;
         end else begin
            right_in = rd_data_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_item;
      end
      if (cmd.exec) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      popped_ff    <= popped_in;
      pop_valid_ff <= pop_valid_in;
      error_ff     <= error_in;
      load_left_ff <= load_left_in;
   end

   assign rsp_popped     = popped_ff;
   assign rsp_pop_valid  = pop_valid_ff;
   assign rsp_error      = error_ff;
   assign rsp_left_word  = is_empty ? '0 : left_ff;
   assign rsp_right_word = is_empty ? '0 : right_ff;
   assign rsp_empty_res  = is_empty;
   assign rsp_count      = fill_ff;

   `DQ_ASSERT(a_fill_bound, clock, reset, (fill_ff <= FULL_V), "fill beyond depth")
   `DQ_ASSERT(a_idle_hold, clock, reset, !cmd.exec |=> ($stable(fill_ff) && $stable(head_ff)), "state moved without a request")
   `DQ_ASSERT(a_load_nonempty, clock, reset, cmd.load |-> (fill_ff >= ONE_V), "end-word reload on empty queue")

endmodule

/* sv/double_ended_queue.sv */
// Timing: the response beat is presented in the cycle after the request beat
// is taken for pushes, errors and pops that leave the queue empty; pops that
// reload an end word from the ring store pass through the read state first,
// as the store's read port is registered. Handshake: one request in flight;
// a new beat is taken once the response beat has been taken.
// Reset: synchronous; the queue comes up empty, store contents unchanged.
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque over a ring store: push right, pop left, pop right.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH      = dq_pkg::DQ_DEPTH,
   parameter int WORD_WIDTH = dq_pkg::DQ_WORD_WIDTH,
   parameter int CW         = $clog2(DEPTH + 1),
   parameter int REQ_TD_W   = ((WORD_WIDTH + 7) / 8) * 8,
   parameter int RSP_TD_W   = ((3 * WORD_WIDTH + 1 + CW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_TD_W-1:0] req_tdata,   // item
   input  logic [1:0]          req_tuser,   // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_TD_W-1:0] rsp_tdata,   // popped, left_word, right_word, empty_res, count
   output logic [1:0]          rsp_tuser    // pop_valid, error
);
   import dq_pkg::*;

   dq_cmd_type            cmd;
   dq_sts_type            sts;
   logic [WORD_WIDTH-1:0] popped;
   logic                  pop_valid;
   logic                  error;
   logic [WORD_WIDTH-1:0] left_word;
   logic [WORD_WIDTH-1:0] right_word;
   logic                  empty_res;
   logic [CW-1:0]         count;

   dq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   dq_datapath #(
      .DEPTH      (DEPTH),
      .WORD_WIDTH (WORD_WIDTH),
      .AW         ($clog2(DEPTH)),
      .CW         (CW)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_action     (req_tuser),
      .req_item       (req_tdata[WORD_WIDTH-1:0]),
      .rsp_popped     (popped),
      .rsp_pop_valid  (pop_valid),
      .rsp_error      (error),
      .rsp_left_word  (left_word),
      .rsp_right_word (right_word),
      .rsp_empty_res  (empty_res),
      .rsp_count      (count)
   );

   assign rsp_tdata = RSP_TD_W'({count, empty_res, right_word, left_word, popped});
   assign rsp_tuser = {error, pop_valid};

endmodule

/* tb/double_ended_queue_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches both streams of the deque, keeps its own model of the ring,
// predicts each response beat and compares it field by field.
// ----------------------------------------------------------------------------
module double_ended_queue_checker #(
   parameter int CW       = $clog2(dq_pkg::DQ_DEPTH + 1),
   parameter int REQ_TD_W = ((dq_pkg::DQ_WORD_WIDTH + 7) / 8) * 8,
   parameter int RSP_TD_W = ((3 * dq_pkg::DQ_WORD_WIDTH + 1 + CW + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [REQ_TD_W-1:0] req_tdata,
   input  logic [1:0]          req_tuser,
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RSP_TD_W-1:0] rsp_tdata,
   input  logic [1:0]          rsp_tuser,
   output int                  fail_count,
   output int                  open_beats,
   output int                  beats_checked,
   output int                  pops_done,
   output int                  errors_seen,
   output int                  full_rejects,
   output int                  peak_fill
);
   import dq_pkg::*;

   typedef logic [DQ_WORD_WIDTH-1:0] word_type;

   typedef struct packed {
      word_type      popped;
      logic          pop_valid;
      logic          error;
      word_type      left_word;
      word_type      right_word;
      logic          empty_res;
      logic [CW-1:0] count;
   } deque_result_type;

   word_type         ring_words [DQ_DEPTH];
   int               left_slot;
   int               words_held;
   deque_result_type predicted_q [$];

   initial begin
      left_slot     = 0;
      words_held    = 0;
      fail_count    = 0;
      open_beats    = 0;
      beats_checked = 0;
      pops_done     = 0;
      errors_seen   = 0;
      full_rejects  = 0;
      peak_fill     = 0;
   end

   function automatic int slot_at(int offset);
      return (left_slot + offset) % DQ_DEPTH;
   endfunction

   function automatic deque_result_type predict_deque_op(logic [1:0] op, word_type word);
      deque_result_type r;
      r = '0;
      case (op)
         ACT_PUSH_RIGHT: begin
            if (words_held >= DQ_DEPTH) begin
               r.error = 1'b1;
            end else begin
               ring_words[slot_at(words_held)] = word;
               words_held++;
            end
         end
         ACT_POP_LEFT: begin
            if (words_held == 0) begin
               r.error = 1'b1;
            end else begin
               r.popped    = ring_words[left_slot];
               r.pop_valid = 1'b1;
               left_slot   = slot_at(1);
               words_held--;
            end
         end
         ACT_POP_RIGHT: begin
            if (words_held == 0) begin
               r.error = 1'b1;
            end else begin
               r.popped    = ring_words[slot_at(words_held - 1)];
               r.pop_valid = 1'b1;
               words_held--;
            end
         end
         default: r.error = 1'b1;
      endcase
      if (words_held != 0) begin
         r.left_word  = ring_words[left_slot];
         r.right_word = ring_words[slot_at(words_held - 1)];
      end
      r.empty_res = (words_held == 0);
      r.count     = CW'(words_held);
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("[%0t] response mismatch on %s: got %0h, want %0h", $time, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      deque_result_type got;
      deque_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.popped     = rsp_tdata[0 +: DQ_WORD_WIDTH];
            got.left_word  = rsp_tdata[DQ_WORD_WIDTH +: DQ_WORD_WIDTH];
            got.right_word = rsp_tdata[2 * DQ_WORD_WIDTH +: DQ_WORD_WIDTH];
            got.empty_res  = rsp_tdata[3 * DQ_WORD_WIDTH];
            got.count      = rsp_tdata[3 * DQ_WORD_WIDTH + 1 +: CW];
            got.pop_valid  = rsp_tuser[0];
            got.error      = rsp_tuser[1];
            beats_checked++;
            if (predicted_q.size() == 0) begin
               report_mismatch("beat with nothing pending", 64'(got.popped), 64'd0);
            end else begin
               want = predicted_q.pop_front();
               if (got.popped !== want.popped)
                  report_mismatch("popped", 64'(got.popped), 64'(want.popped));
               if (got.pop_valid !== want.pop_valid)
                  report_mismatch("pop_valid", 64'(got.pop_valid), 64'(want.pop_valid));
               if (got.error !== want.error)
                  report_mismatch("error", 64'(got.error), 64'(want.error));
               if (got.left_word !== want.left_word)
                  report_mismatch("left_word", 64'(got.left_word), 64'(want.left_word));
               if (got.right_word !== want.right_word)
                  report_mismatch("right_word", 64'(got.right_word), 64'(want.right_word));
               if (got.empty_res !== want.empty_res)
                  report_mismatch("empty_res", 64'(got.empty_res), 64'(want.empty_res));
               if (got.count !== want.count)
                  report_mismatch("count", 64'(got.count), 64'(want.count));
            end
         end
         if (req_tvalid && req_tready) begin
            want = predict_deque_op(req_tuser, req_tdata[0 +: DQ_WORD_WIDTH]);
            predicted_q = {predicted_q, want};
            pops_done   += want.pop_valid;
            errors_seen += want.error;
            if (req_tuser == ACT_PUSH_RIGHT && want.error)
               full_rejects++;
            if (words_held > peak_fill)
               peak_fill = words_held;
         end
         open_beats = predicted_q.size();
      end
   end

endmodule

/* tb/double_ended_queue_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Drives push, pop-left, pop-right and illegal requests into the deque in
// bursts, with a stalling response sink, and lets the checker verify every
// response beat.
// ----------------------------------------------------------------------------
module double_ended_queue_test;
   import dq_pkg::*;

   localparam int         CW          = $clog2(DQ_DEPTH + 1);
   localparam int         REQ_TD_W    = ((DQ_WORD_WIDTH + 7) / 8) * 8;
   localparam int         RSP_TD_W    = ((3 * DQ_WORD_WIDTH + 1 + CW + 7) / 8) * 8;
   localparam logic [1:0] ACT_ILLEGAL = 2'd3;
   localparam int         RANDOM_BEATS = 900;
   localparam int         HOLD_CYCLES  = 200;

   logic                clock;
   logic                reset;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_TD_W-1:0] req_tdata  = '0;
   logic [1:0]          req_tuser  = ACT_PUSH_RIGHT;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_TD_W-1:0] rsp_tdata;
   logic [1:0]          rsp_tuser;

   int fail_count, open_beats, beats_checked, pops_done;
   int errors_seen, full_rejects, peak_fill;
   bit hold_sink = 1'b0;
   bit stim_done = 1'b0;

   double_ended_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   double_ended_queue_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fail_count    (fail_count),
      .open_beats    (open_beats),
      .beats_checked (beats_checked),
      .pops_done     (pops_done),
      .errors_seen   (errors_seen),
      .full_rejects  (full_rejects),
      .peak_fill     (peak_fill)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // response sink: switches between random stall patterns, long hold on request
   initial begin : sink
      int mode;
      int ticks;
      mode  = 0;
      ticks = 0;
      forever begin
         @(negedge clock);
         if (hold_sink) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
            hold_sink = 1'b0;
         end else begin
            if (ticks % 50 == 0)
               mode = stim_done ? 0 : int'($urandom_range(0, 3));
            ticks++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (ticks % 5 == 0);
               default: rsp_tready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   task automatic send_beat(logic [1:0] op, logic [DQ_WORD_WIDTH-1:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= REQ_TD_W'(word);
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_tvalid <= 1'b0;
      wait (open_beats == 0);
      @(negedge clock);
   endtask

   function automatic logic [DQ_WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return DQ_WORD_WIDTH'(1) << $urandom_range(0, DQ_WORD_WIDTH - 1);
         default: return DQ_WORD_WIDTH'($urandom);
      endcase
   endfunction

   // bias: 0 fill, 1 mixed, 2 drain, 3 mixed with illegal actions
   function automatic logic [1:0] pick_action(int bias);
      int roll;
      roll = $urandom_range(0, 99);
      case (bias)
         0:       return (roll < 85) ? ACT_PUSH_RIGHT : (roll < 93 ? ACT_POP_LEFT : ACT_POP_RIGHT);
         2:       return (roll < 15) ? ACT_PUSH_RIGHT : (roll < 58 ? ACT_POP_LEFT : ACT_POP_RIGHT);
         3: begin
            if (roll < 10) return ACT_ILLEGAL;
            return (roll < 55) ? ACT_PUSH_RIGHT : (roll < 78 ? ACT_POP_LEFT : ACT_POP_RIGHT);
         end
         default: return (roll < 50) ? ACT_PUSH_RIGHT : (roll < 75 ? ACT_POP_LEFT : ACT_POP_RIGHT);
      endcase
   endfunction

   initial begin : stimulus
      int sent;
      int phase;
      int phase_len;
      int burst_left;
      int gap;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_beat(ACT_POP_LEFT,   32'h0000_0000);
      send_beat(ACT_POP_RIGHT,  32'hFFFF_FFFF);
      send_beat(ACT_ILLEGAL,    32'h1234_5678);
      send_beat(ACT_PUSH_RIGHT, 32'h0000_0000);
      send_beat(ACT_POP_LEFT,   32'hFFFF_FFFF);
      send_beat(ACT_PUSH_RIGHT, 32'hFFFF_FFFF);
      send_beat(ACT_PUSH_RIGHT, 32'h8000_0000);
      send_beat(ACT_PUSH_RIGHT, 32'h0000_0001);
      send_beat(ACT_ILLEGAL,    32'hFFFF_FFFF);
      send_beat(ACT_POP_RIGHT,  32'h0000_0000);
      send_beat(ACT_POP_LEFT,   32'h0000_0000);
      send_beat(ACT_POP_LEFT,   32'h0000_0000);
      send_beat(ACT_POP_RIGHT,  32'h0000_0000);
      send_beat(ACT_PUSH_RIGHT, 32'hA5A5_A5A5);
      send_beat(ACT_PUSH_RIGHT, 32'h5A5A_5A5A);
      send_beat(ACT_POP_RIGHT,  32'h0000_0000);
      send_beat(ACT_POP_RIGHT,  32'h0000_0000);
      send_beat(ACT_POP_LEFT,   32'h0000_0000);
      drain_all();

      sent  = 0;
      phase = 0;
      while (sent < RANDOM_BEATS) begin
         phase_len = (phase % 4 == 0) ? $urandom_range(90, 120) : $urandom_range(30, 90);
         // hold the sink off in phases 1 and 6, so the sender stalls behind it
         if (phase == 1 || phase == 6)
            hold_sink = 1'b1;
         burst_left = $urandom_range(1, 16);
         repeat (phase_len) begin
            send_beat(pick_action(phase % 4), pick_word());
            sent++;
            burst_left--;
            if (burst_left == 0) begin
               gap = $urandom_range(0, 8);
               if (gap > 0) begin
                  req_tvalid <= 1'b0;
                  repeat (gap) @(negedge clock);
               end
               burst_left = $urandom_range(1, 16);
            end
         end
         if (phase % 3 == 2)
            drain_all();
         phase++;
      end

      stim_done = 1'b1;
      req_tvalid <= 1'b0;
      wait (open_beats == 0);
      repeat (20) @(posedge clock);
      $display("Checked %0d response beats: %0d pops, %0d errors, %0d pushes refused when full",
               beats_checked, pops_done, errors_seen, full_rejects);
      $display("Deepest fill reached: %0d of %0d words", peak_fill, DQ_DEPTH);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
